/* hw/rtl/wreu_pkg.sv */
// Shared types and constants of the windowed register execute unit.
`default_nettype none
package wreu_pkg;

    typedef enum logic [5:0] {
        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NEG, OP_ADDI, OP_MOVI,
        OP_L8UI, OP_L16UI, OP_L16SI, OP_L32I, OP_S8I, OP_S16I, OP_S32I,
        OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU, OP_BEQZ, OP_BNEZ,
        OP_BLTZ, OP_BGEZ, OP_L32R, OP_J, OP_JX, OP_CALL8, OP_CALLX8,
        OP_ENTRY, OP_RETW, OP_BREAK, OP_SLLI, OP_SRAI, OP_SRLI, OP_SSL,
        OP_SSR, OP_SLL, OP_SRL, OP_SRA, OP_MULL, OP_QUOU, OP_QUOS, OP_REMU,
        OP_REMS, OP_INVALID
    } op_t;

    typedef enum logic [2:0] {
        ST_OK, ST_MEM, ST_HALTED, ST_DEPTH, ST_INVALID, ST_TRAP
    } status_t;

    typedef enum logic [1:0] {
        LK_U8, LK_U16, LK_S16, LK_W32
    } load_kind_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RDB, S_RDD, S_EXEC, S_MUL, S_DIV, S_SAVE, S_MARK,
        S_REST, S_RET10, S_RET11, S_DONE
    } fsm_t;

    typedef struct packed {
        logic start;
        logic is_signed;
        logic want_rem;
    } div_req_t;

    localparam logic CFG_START_PC  = 1'b0;
    localparam logic CFG_STACK_TOP = 1'b1;

    localparam int NREG = 64;

endpackage
`default_nettype wire

/* hw/rtl/wreu_ram.sv */
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module wreu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/wreu_div.sv */
// Radix-2 iterative divider for quou, quos, remu and rems.
`default_nettype none
module wreu_div
    import wreu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire div_req_t    req,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic      [31:0] result
);

    logic        busy_reg;
    logic        fin_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] ub_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic        want_rem_reg;
    logic [32:0] shifted;
    logic        fits;
    logic [31:0] ua;
    logic [31:0] ub;

    assign shifted = {rem_reg, quo_reg[31]};
    assign fits    = shifted >= {1'b0, ub_reg};
    assign ua      = (req.is_signed && dividend[31]) ? (32'd0 - dividend) : dividend;
    assign ub      = (req.is_signed && divisor[31]) ? (32'd0 - divisor) : divisor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done    <= 1'b0;
            fin_reg <= 1'b0;
            if (req.start)
            begin
                want_rem_reg <= req.want_rem;
                if (divisor == 32'd0)
                begin
                    // divide by zero: all ones quotient, dividend remainder
                    result <= req.want_rem ? dividend : 32'hffff_ffff;
                    done   <= 1'b1;
                end
                else if (req.is_signed && dividend == 32'h8000_0000
                         && divisor == 32'hffff_ffff)
                begin
                    result <= req.want_rem ? 32'd0 : 32'h8000_0000;
                    done   <= 1'b1;
                end
                else
                begin
                    busy_reg  <= 1'b1;
                    cnt_reg   <= '0;
                    quo_reg   <= ua;
                    rem_reg   <= '0;
                    ub_reg    <= ub;
                    neg_q_reg <= req.is_signed && (dividend[31] ^ divisor[31]);
                    neg_r_reg <= req.is_signed && dividend[31];
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? 32'(shifted - {1'b0, ub_reg}) : shifted[31:0];
                quo_reg <= {quo_reg[30:0], fits};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                if (want_rem_reg)
                begin
                    result <= neg_r_reg ? (32'd0 - rem_reg) : rem_reg;
                end
                else
                begin
                    result <= neg_q_reg ? (32'd0 - quo_reg) : quo_reg;
                end
                done <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/windowed_risc_execute_unit.sv */
// Top level of the windowed register execute unit.
//
// Usage: one decoded instruction (tuser = 0) or one load return (tuser = 1)
// per input transaction on s_axis; exactly one result transaction per input
// on m_axis (tuser = status, tdata = next pc, memory request fields and trap code).
// Configuration writes on cfg_* (index 0 start pc, index 1 stack top) are
// taken only while the unit sits idle.
// Steps per item: a load return goes straight to the result; ALU, shift,
// branch and memory request items take three register file reads through
// the one read port of the 64-entry register RAM, then execute; mull goes
// through the multiply state; quou/quos/remu/rems run the divider (one
// quotient bit per cycle); call8/callx8 and retw add the 64-entry sweep
// between the register RAM and the frame RAM. Items are processed one at a time.
// The result sits in an output register: a new item is accepted while it
// waits, and the unit holds the next result until the receiver drains it.
// Reset clears the valid bits of the register file (all registers read as
// zero), the window base, call depth and pending load, and sets the pc to 0.
`default_nettype none
module windowed_risc_execute_unit
    import wreu_pkg::*;
#(
    parameter int FRAME_DEPTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // opcode[5:0] dest_reg[9:6] src_a[13:10] src_b[17:14] immediate[49:18]
    // instr_bytes[51:50] load_data[83:52], zero pad to 88
    input  wire logic [87:0]  s_axis_tdata,
    // operation[0]
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // next_pc[31:0] mem_address[63:32] mem_is_write[64] mem_bytes[67:65]
    // mem_write_data[99:68] trap_code[131:100], zero pad to 136
    output logic      [135:0] m_axis_tdata,
    // status[2:0]
    output logic      [2:0]   m_axis_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data
);

    localparam int FIW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int FCW = $clog2(FRAME_DEPTH + 1);
    localparam int FAW = $clog2(FRAME_DEPTH * NREG);

    fsm_t state_reg, state_next;

    // input fields
    logic        in_acc;
    logic        in_op;
    logic [5:0]  in_opcode;
    logic [3:0]  in_dst;
    logic [3:0]  in_sa;
    logic [3:0]  in_sb;
    logic [31:0] in_imm;
    logic [1:0]  in_len;
    logic [31:0] in_ld;

    // architectural state
    logic [31:0]      pc_reg;
    logic [5:0]       wb_reg;
    logic [3:0]       ci_reg;
    logic [4:0]       sar_reg;
    logic [FCW-1:0]   fc_reg;
    logic             running_reg;
    logic             pend_valid_reg;
    load_kind_t       pend_kind_reg;
    logic [3:0]       pend_dst_reg;
    logic [NREG-1:0]  vld_reg;

    // item working registers
    op_t         op_reg;
    logic [3:0]  dst_reg;
    logic [3:0]  sa_reg;
    logic [3:0]  sb_reg;
    logic [31:0] imm_reg;
    logic [1:0]  len_reg;
    logic [31:0] lhs_reg;
    logic [31:0] rhs_reg;
    logic [31:0] prod_reg;
    logic [31:0] seq_reg;
    logic [6:0]  idx_reg;
    logic        rd_vld_reg;

    // pending result
    status_t     res_status_reg;
    logic [31:0] res_next_reg;
    logic [31:0] res_addr_reg;
    logic        res_wr_reg;
    logic [2:0]  res_bytes_reg;
    logic [31:0] res_data_reg;
    logic [31:0] res_trap_reg;

    // output register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [31:0] out_next_reg;
    logic [31:0] out_addr_reg;
    logic        out_wr_reg;
    logic [2:0]  out_bytes_reg;
    logic [31:0] out_data_reg;
    logic [31:0] out_trap_reg;

    // register file RAM
    logic        rf_we;
    logic [5:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic [5:0]  rf_raddr;
    logic [31:0] rf_rdata;
    logic [31:0] rf_rd;

    // frame RAMs
    logic           fr_we;
    logic [FAW-1:0] fr_waddr;
    logic [FAW-1:0] fr_raddr;
    logic [31:0]    fr_rdata;
    logic           meta_we;
    logic [37:0]    meta_rdata;
    logic [FIW-1:0] slot_call;
    logic [FIW-1:0] slot_ret;
    logic [6:0]     idx_m1;
    logic           frame_full;

    // execute
    logic [31:0] seq_pc;
    logic [31:0] tgt_pc;
    logic [31:0] ex_next;
    logic        take;
    logic        alu_we;
    logic [31:0] alu_val;
    logic [31:0] ld_ext;
    logic        cfg_acc;
    logic        out_free;
    logic        is_div;

    div_req_t    div_req;
    logic        div_done;
    logic [31:0] div_res;

    assign in_opcode = s_axis_tdata[5:0];
    assign in_dst    = s_axis_tdata[9:6];
    assign in_sa     = s_axis_tdata[13:10];
    assign in_sb     = s_axis_tdata[17:14];
    assign in_imm    = s_axis_tdata[49:18];
    assign in_len    = s_axis_tdata[51:50];
    assign in_ld     = s_axis_tdata[83:52];
    assign in_op     = s_axis_tuser[0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_acc       = cfg_valid && cfg_ready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {4'd0, out_trap_reg, out_data_reg, out_bytes_reg,
                            out_wr_reg, out_addr_reg, out_next_reg};

    assign slot_call  = fc_reg[FIW-1:0];
    assign slot_ret   = FIW'(fc_reg - FCW'(1));
    assign idx_m1     = idx_reg - 7'd1;
    assign frame_full = fc_reg >= FCW'(FRAME_DEPTH);
    assign is_div     = (op_reg == OP_QUOU) || (op_reg == OP_QUOS)
                     || (op_reg == OP_REMU) || (op_reg == OP_REMS);

    // Never-written registers read as zero.
    assign rf_rd = rd_vld_reg ? rf_rdata : 32'd0;

    assign seq_pc = pc_reg + {30'd0, len_reg};
    assign tgt_pc = pc_reg + 32'd4 + imm_reg;

    always_comb
    begin
        case (pend_kind_reg)
            LK_U8:   ld_ext = {24'd0, in_ld[7:0]};
            LK_U16:  ld_ext = {16'd0, in_ld[15:0]};
            LK_S16:  ld_ext = {{16{in_ld[15]}}, in_ld[15:0]};
            default: ld_ext = in_ld;
        endcase
    end

    // Branch decision and next pc of the executing instruction.
    always_comb
    begin
        take = 1'b0;
        case (op_reg)
            OP_BEQ:  take = lhs_reg == rhs_reg;
            OP_BNE:  take = lhs_reg != rhs_reg;
            OP_BLT:  take = $signed(lhs_reg) < $signed(rhs_reg);
            OP_BGE:  take = $signed(lhs_reg) >= $signed(rhs_reg);
            OP_BLTU: take = lhs_reg < rhs_reg;
            OP_BGEU: take = lhs_reg >= rhs_reg;
            OP_BEQZ: take = lhs_reg == 32'd0;
            OP_BNEZ: take = lhs_reg != 32'd0;
            OP_BLTZ: take = lhs_reg[31];
            OP_BGEZ: take = !lhs_reg[31];
            OP_J:    take = 1'b1;
            default: take = 1'b0;
        endcase
        case (op_reg)
            OP_JX, OP_CALLX8: ex_next = lhs_reg;
            OP_CALL8:         ex_next = {pc_reg[31:2], 2'b00} + 32'd4 + imm_reg;
            default:          ex_next = take ? tgt_pc : seq_pc;
        endcase
    end

    // Combinational results that go straight to the destination register.
    always_comb
    begin
        alu_we = 1'b1;
        case (op_reg)
            OP_ADD:  alu_val = lhs_reg + rhs_reg;
            OP_SUB:  alu_val = lhs_reg - rhs_reg;
            OP_AND:  alu_val = lhs_reg & rhs_reg;
            OP_OR:   alu_val = lhs_reg | rhs_reg;
            OP_XOR:  alu_val = lhs_reg ^ rhs_reg;
            OP_NEG:  alu_val = 32'd0 - lhs_reg;
            OP_ADDI: alu_val = lhs_reg + imm_reg;
            OP_MOVI: alu_val = imm_reg;
            OP_SLLI: alu_val = lhs_reg << imm_reg[4:0];
            OP_SRAI: alu_val = 32'($signed(lhs_reg) >>> imm_reg[4:0]);
            OP_SRLI: alu_val = lhs_reg >> imm_reg[4:0];
            OP_SLL:  alu_val = lhs_reg << sar_reg;
            OP_SRL:  alu_val = lhs_reg >> sar_reg;
            OP_SRA:  alu_val = 32'($signed(lhs_reg) >>> sar_reg);
            default:
            begin
                alu_we  = 1'b0;
                alu_val = 32'd0;
            end
        endcase
    end

    // Register file read address: operands, then the call snapshot sweep.
    always_comb
    begin
        case (state_reg)
            S_IDLE:
                rf_raddr = wb_reg + ((in_opcode == 6'(OP_RETW)) ? 6'd2 : {2'd0, in_sa});
            S_RDB:
                rf_raddr = wb_reg + ((op_reg == OP_RETW) ? 6'd3 : {2'd0, sb_reg});
            S_RDD:   rf_raddr = wb_reg + {2'd0, dst_reg};
            S_SAVE:  rf_raddr = idx_reg[5:0];
            default: rf_raddr = 6'd0;
        endcase
    end

    // Register file write port.
    always_comb
    begin
        rf_we    = 1'b0;
        rf_waddr = 6'd0;
        rf_wdata = 32'd0;
        if (cfg_acc && cfg_index == CFG_STACK_TOP)
        begin
            rf_we    = 1'b1;
            rf_waddr = wb_reg + 6'd1;
            rf_wdata = cfg_data;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && in_op && running_reg && pend_valid_reg)
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = wb_reg + {2'd0, pend_dst_reg};
                        rf_wdata = ld_ext;
                    end
                end
                S_EXEC:
                begin
                    if (alu_we)
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = wb_reg + {2'd0, dst_reg};
                        rf_wdata = alu_val;
                    end
                    else if (op_reg == OP_ENTRY)
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = wb_reg + {2'd0, ci_reg} + {2'd0, sa_reg};
                        rf_wdata = lhs_reg - imm_reg;
                    end
                end
                S_MUL:
                begin
                    rf_we    = 1'b1;
                    rf_waddr = wb_reg + {2'd0, dst_reg};
                    rf_wdata = prod_reg;
                end
                S_DIV:
                begin
                    rf_we    = div_done;
                    rf_waddr = wb_reg + {2'd0, dst_reg};
                    rf_wdata = div_res;
                end
                S_MARK:
                begin
                    // return marker in the caller's a8
                    rf_we    = 1'b1;
                    rf_waddr = wb_reg + 6'd8;
                    rf_wdata = 32'h8000_0000 | (seq_reg & 32'h3fff_ffff);
                end
                S_REST:
                begin
                    rf_we    = idx_reg != 7'd0;
                    rf_waddr = idx_m1[5:0];
                    rf_wdata = fr_rdata;
                end
                S_RET10:
                begin
                    rf_we    = 1'b1;
                    rf_waddr = wb_reg + 6'd10;
                    rf_wdata = lhs_reg;
                end
                S_RET11:
                begin
                    rf_we    = 1'b1;
                    rf_waddr = wb_reg + 6'd11;
                    rf_wdata = rhs_reg;
                end
                default:
                begin
                    rf_we = 1'b0;
                end
            endcase
        end
    end

    // Snapshot sweep: one register per cycle between the two RAMs.
    assign fr_we    = (state_reg == S_SAVE) && (idx_reg != 7'd0);
    assign fr_waddr = FAW'({slot_call, idx_m1[5:0]});
    assign fr_raddr = FAW'({slot_ret, idx_reg[5:0]});
    assign meta_we  = (state_reg == S_EXEC) && !frame_full
                   && ((op_reg == OP_CALL8) || (op_reg == OP_CALLX8));

    assign div_req.start     = (state_reg == S_EXEC) && is_div;
    assign div_req.is_signed = (op_reg == OP_QUOS) || (op_reg == OP_REMS);
    assign div_req.want_rem  = (op_reg == OP_REMU) || (op_reg == OP_REMS);

    wreu_ram #(.WIDTH(32), .DEPTH(NREG)) u_regfile (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    wreu_ram #(.WIDTH(32), .DEPTH(FRAME_DEPTH * NREG)) u_frame_regs (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (rf_rd),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    // Return pc in the upper bits, caller window base in the lower six.
    wreu_ram #(.WIDTH(38), .DEPTH(FRAME_DEPTH)) u_frame_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (slot_call),
        .wdata ({seq_pc, wb_reg}),
        .raddr (slot_ret),
        .rdata (meta_rdata)
    );

    wreu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (lhs_reg),
        .divisor  (rhs_reg),
        .done     (div_done),
        .result   (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (!running_reg || in_op || pend_valid_reg
                        || in_opcode >= 6'(OP_INVALID))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RDB;
                    end
                end
            end
            S_RDB:  state_next = S_RDD;
            S_RDD:  state_next = S_EXEC;
            S_EXEC:
            begin
                case (op_reg)
                    OP_MULL:            state_next = S_MUL;
                    OP_QUOU, OP_QUOS,
                    OP_REMU, OP_REMS:   state_next = S_DIV;
                    OP_CALL8, OP_CALLX8:
                        state_next = frame_full ? S_DONE : S_SAVE;
                    OP_RETW:
                        state_next = (fc_reg == '0) ? S_DONE : S_REST;
                    default:            state_next = S_DONE;
                endcase
            end
            S_MUL:   state_next = S_DONE;
            S_DIV:   state_next = div_done ? S_DONE : S_DIV;
            S_SAVE:  state_next = (idx_reg == 7'd64) ? S_MARK : S_SAVE;
            S_MARK:  state_next = S_DONE;
            S_REST:  state_next = (idx_reg == 7'd64) ? S_RET10 : S_REST;
            S_RET10: state_next = S_RET11;
            S_RET11: state_next = S_DONE;
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= 32'd0;
            wb_reg         <= 6'd0;
            ci_reg         <= 4'd0;
            sar_reg        <= 5'd0;
            fc_reg         <= '0;
            running_reg    <= 1'b1;
            pend_valid_reg <= 1'b0;
            vld_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            idx_reg        <= 7'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rf_raddr];
            if (rf_we)
            begin
                vld_reg[rf_waddr] <= 1'b1;
            end
            if (cfg_acc && cfg_index == CFG_START_PC)
            begin
                pc_reg <= cfg_data;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && running_reg && in_op && pend_valid_reg)
                    begin
                        pend_valid_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    idx_reg <= 7'd0;
                    case (op_reg)
                        OP_L8UI, OP_L16UI, OP_L16SI, OP_L32I, OP_L32R:
                        begin
                            pend_valid_reg <= 1'b1;
                            pc_reg         <= ex_next;
                        end
                        OP_CALL8, OP_CALLX8:
                        begin
                            if (frame_full)
                            begin
                                running_reg <= 1'b0;
                            end
                            else
                            begin
                                pc_reg <= ex_next;
                            end
                        end
                        OP_RETW:
                        begin
                            if (fc_reg == '0)
                            begin
                                running_reg <= 1'b0;
                            end
                        end
                        OP_ENTRY:
                        begin
                            wb_reg <= wb_reg + {2'd0, ci_reg};
                            ci_reg <= 4'd0;
                            pc_reg <= ex_next;
                        end
                        OP_SSL, OP_SSR:
                        begin
                            sar_reg <= lhs_reg[4:0];
                            pc_reg  <= ex_next;
                        end
                        default:
                        begin
                            pc_reg <= ex_next;
                        end
                    endcase
                end
                S_SAVE:
                begin
                    idx_reg <= idx_reg + 7'd1;
                end
                S_MARK:
                begin
                    fc_reg <= fc_reg + FCW'(1);
                    ci_reg <= 4'd8;
                end
                S_REST:
                begin
                    idx_reg <= idx_reg + 7'd1;
                    if (idx_reg == 7'd64)
                    begin
                        // switch to the caller's window before a10/a11
                        wb_reg <= meta_rdata[5:0];
                    end
                end
                S_RET11:
                begin
                    fc_reg <= fc_reg - FCW'(1);
                    pc_reg <= meta_rdata[37:6];
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_reg  <= (in_opcode >= 6'(OP_INVALID)) ? OP_INVALID : op_t'(in_opcode);
                    dst_reg <= in_dst;
                    sa_reg  <= in_sa;
                    sb_reg  <= in_sb;
                    imm_reg <= in_imm;
                    len_reg <= in_len;
                    res_next_reg  <= pc_reg;
                    res_addr_reg  <= 32'd0;
                    res_wr_reg    <= 1'b0;
                    res_bytes_reg <= 3'd0;
                    res_data_reg  <= 32'd0;
                    res_trap_reg  <= 32'd0;
                    if (!running_reg)
                    begin
                        res_status_reg <= ST_HALTED;
                    end
                    else if (in_op)
                    begin
                        res_status_reg <= pend_valid_reg ? ST_OK : ST_INVALID;
                    end
                    else if (pend_valid_reg || in_opcode >= 6'(OP_INVALID))
                    begin
                        res_status_reg <= ST_INVALID;
                    end
                    else
                    begin
                        res_status_reg <= ST_OK;
                    end
                end
            end
            S_RDB: lhs_reg <= rf_rd;
            S_RDD: rhs_reg <= rf_rd;
            S_EXEC:
            begin
                prod_reg     <= lhs_reg * rhs_reg;
                seq_reg      <= seq_pc;
                res_next_reg <= ex_next;
                case (op_reg)
                    OP_L8UI, OP_L16UI, OP_L16SI, OP_L32I, OP_L32R:
                    begin
                        res_status_reg <= ST_MEM;
                        pend_dst_reg   <= dst_reg;
                        case (op_reg)
                            OP_L8UI:
                            begin
                                pend_kind_reg <= LK_U8;
                                res_bytes_reg <= 3'd1;
                            end
                            OP_L16UI:
                            begin
                                pend_kind_reg <= LK_U16;
                                res_bytes_reg <= 3'd2;
                            end
                            OP_L16SI:
                            begin
                                pend_kind_reg <= LK_S16;
                                res_bytes_reg <= 3'd2;
                            end
                            default:
                            begin
                                pend_kind_reg <= LK_W32;
                                res_bytes_reg <= 3'd4;
                            end
                        endcase
                        if (op_reg == OP_L32R)
                        begin
                            res_addr_reg <= ((pc_reg + 32'd3) & ~32'd3) + imm_reg;
                        end
                        else
                        begin
                            res_addr_reg <= lhs_reg + imm_reg;
                        end
                    end
                    OP_S8I, OP_S16I, OP_S32I:
                    begin
                        // rf_rd holds the store source read in the last cycle
                        res_status_reg <= ST_MEM;
                        res_wr_reg     <= 1'b1;
                        res_addr_reg   <= lhs_reg + imm_reg;
                        case (op_reg)
                            OP_S8I:
                            begin
                                res_bytes_reg <= 3'd1;
                                res_data_reg  <= {24'd0, rf_rd[7:0]};
                            end
                            OP_S16I:
                            begin
                                res_bytes_reg <= 3'd2;
                                res_data_reg  <= {16'd0, rf_rd[15:0]};
                            end
                            default:
                            begin
                                res_bytes_reg <= 3'd4;
                                res_data_reg  <= rf_rd;
                            end
                        endcase
                    end
                    OP_CALL8, OP_CALLX8:
                    begin
                        if (frame_full)
                        begin
                            res_status_reg <= ST_DEPTH;
                            res_next_reg   <= pc_reg;
                        end
                    end
                    OP_RETW:
                    begin
                        if (fc_reg == '0)
                        begin
                            res_status_reg <= ST_HALTED;
                            res_next_reg   <= pc_reg;
                        end
                    end
                    OP_BREAK:
                    begin
                        res_status_reg <= ST_TRAP;
                        res_trap_reg   <= imm_reg;
                    end
                    default:
                    begin
                        res_status_reg <= ST_OK;
                    end
                endcase
            end
            S_RET11:
            begin
                res_next_reg <= meta_rdata[37:6];
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    out_next_reg   <= res_next_reg;
                    out_addr_reg   <= res_addr_reg;
                    out_wr_reg     <= res_wr_reg;
                    out_bytes_reg  <= res_bytes_reg;
                    out_data_reg   <= res_data_reg;
                    out_trap_reg   <= res_trap_reg;
                end
            end
            default:
            begin
                lhs_reg <= lhs_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

/* verif/tb_windowed_risc_execute_unit.sv */
// Testbench for the windowed register execute unit: predicted results, directed and random traffic.
`default_nettype none
module tb_windowed_risc_execute_unit;
    import wreu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // One input transaction: an instruction or the data of a pending load.
    typedef struct {
        logic        is_load_data;
        logic [5:0]  opc;
        logic [3:0]  rd;
        logic [3:0]  ra;
        logic [3:0]  rb;
        logic [31:0] imm;
        logic [1:0]  len;
        logic [31:0] ldata;
    } instr_t;

    // One result transaction.
    typedef struct {
        status_t     st;
        logic [31:0] npc;
        logic [31:0] addr;
        logic        wr;
        logic [2:0]  nbytes;
        logic [31:0] wdata;
        logic [31:0] trap;
    } outcome_t;

    localparam int DEPTH = 16;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [31:0]  cfg_data;

    windowed_risc_execute_unit #(.FRAME_DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the architectural state
    // ------------------------------------------------------------------
    logic [31:0] arch_regs [64];
    logic [5:0]  arch_wbase;
    logic [3:0]  arch_callinc;
    logic [4:0]  arch_sar;
    logic [31:0] arch_pc;
    int          arch_depth;
    logic [31:0] frame_snap [DEPTH][64];
    logic [31:0] frame_ret  [DEPTH];
    logic [5:0]  frame_wbase[DEPTH];
    logic        load_pending;
    load_kind_t  load_kind;
    logic [3:0]  load_reg;
    logic        arch_running;

    outcome_t    expected_results[$];
    int          mismatches;
    int          rx_hold;       // receiver hold-off, counted down by the receiver
    bit          rx_eager;      // receiver takes every result at once
    bit          tx_eager;      // sender offers back to back
    bit          after_call;

    function automatic logic [5:0] phys(input logic [3:0] v);
        return arch_wbase + {2'b00, v};
    endfunction

    function automatic logic [31:0] reg_rd(input logic [3:0] v);
        return arch_regs[phys(v)];
    endfunction

    function automatic void reg_wr(input logic [3:0] v, input logic [31:0] x);
        arch_regs[phys(v)] = x;
    endfunction

    function automatic void arch_reset();
        foreach (arch_regs[i]) arch_regs[i] = '0;
        arch_wbase   = '0;
        arch_callinc = '0;
        arch_sar     = '0;
        arch_pc      = '0;
        arch_depth   = 0;
        load_pending = 1'b0;
        load_kind    = LK_U8;
        load_reg     = '0;
        arch_running = 1'b1;
    endfunction

    // Advance the shadow state by one accepted transaction; return its result.
    function automatic outcome_t execute_instr(input instr_t it);
        outcome_t    r;
        logic [31:0] lhs, rhs, tgt, d, mag_a, mag_b, q;
        logic        commit;
        r = '{st: ST_OK, npc: arch_pc, addr: 0, wr: 0, nbytes: 0, wdata: 0, trap: 0};
        if (!arch_running)
            r.st = ST_HALTED;
        else if (it.is_load_data)
        begin
            if (!load_pending)
                r.st = ST_INVALID;
            else
            begin
                d = it.ldata;
                case (load_kind)
                    LK_U8:   d = {24'd0, d[7:0]};
                    LK_U16:  d = {16'd0, d[15:0]};
                    LK_S16:  d = {{16{d[15]}}, d[15:0]};
                    default: ;
                endcase
                reg_wr(load_reg, d);
                load_pending = 1'b0;
            end
        end
        else if (load_pending)
            r.st = ST_INVALID;
        else
        begin
            lhs    = reg_rd(it.ra);
            rhs    = reg_rd(it.rb);
            tgt    = arch_pc + 32'd4 + it.imm;
            commit = 1'b1;
            r.npc  = arch_pc + {30'd0, it.len};
            case (op_t'(it.opc))
                OP_ADD:  reg_wr(it.rd, lhs + rhs);
                OP_SUB:  reg_wr(it.rd, lhs - rhs);
                OP_AND:  reg_wr(it.rd, lhs & rhs);
                OP_OR:   reg_wr(it.rd, lhs | rhs);
                OP_XOR:  reg_wr(it.rd, lhs ^ rhs);
                OP_NEG:  reg_wr(it.rd, -lhs);
                OP_ADDI: reg_wr(it.rd, lhs + it.imm);
                OP_MOVI: reg_wr(it.rd, it.imm);
                OP_L8UI, OP_L16UI, OP_L16SI, OP_L32I, OP_L32R:
                begin
                    load_kind = (op_t'(it.opc) == OP_L32R) ? LK_W32
                              : load_kind_t'(it.opc - OP_L8UI);
                    r.st   = ST_MEM;
                    r.addr = (op_t'(it.opc) == OP_L32R)
                           ? ((arch_pc + 32'd3) & ~32'd3) + it.imm : lhs + it.imm;
                    r.nbytes = (load_kind == LK_U8) ? 3'd1
                             : (load_kind == LK_W32) ? 3'd4 : 3'd2;
                    load_pending = 1'b1;
                    load_reg     = it.rd;
                end
                OP_S8I, OP_S16I, OP_S32I:
                begin
                    d      = reg_rd(it.rd);
                    r.st   = ST_MEM;
                    r.wr   = 1'b1;
                    r.addr = lhs + it.imm;
                    case (op_t'(it.opc))
                        OP_S8I:  begin r.nbytes = 3'd1; r.wdata = {24'd0, d[7:0]}; end
                        OP_S16I: begin r.nbytes = 3'd2; r.wdata = {16'd0, d[15:0]}; end
                        default: begin r.nbytes = 3'd4; r.wdata = d; end
                    endcase
                end
                OP_BEQ:  if (lhs == rhs) r.npc = tgt;
                OP_BNE:  if (lhs != rhs) r.npc = tgt;
                OP_BLT:  if ($signed(lhs) < $signed(rhs)) r.npc = tgt;
                OP_BGE:  if ($signed(lhs) >= $signed(rhs)) r.npc = tgt;
                OP_BLTU: if (lhs < rhs) r.npc = tgt;
                OP_BGEU: if (lhs >= rhs) r.npc = tgt;
                OP_BEQZ: if (lhs == 0) r.npc = tgt;
                OP_BNEZ: if (lhs != 0) r.npc = tgt;
                OP_BLTZ: if (lhs[31]) r.npc = tgt;
                OP_BGEZ: if (!lhs[31]) r.npc = tgt;
                OP_J:    r.npc = tgt;
                OP_JX:   r.npc = lhs;
                OP_CALL8, OP_CALLX8:
                begin
                    if (arch_depth >= DEPTH)
                    begin
                        arch_running = 1'b0;
                        r.st   = ST_DEPTH;
                        commit = 1'b0;
                        r.npc  = arch_pc;
                    end
                    else
                    begin
                        foreach (arch_regs[i]) frame_snap[arch_depth][i] = arch_regs[i];
                        frame_ret[arch_depth]   = r.npc;
                        frame_wbase[arch_depth] = arch_wbase;
                        arch_depth++;
                        reg_wr(4'd8, {2'b10, r.npc[29:0]});
                        arch_callinc = 4'd8;
                        r.npc = (op_t'(it.opc) == OP_CALL8)
                              ? (arch_pc & ~32'd3) + 32'd4 + it.imm : lhs;
                    end
                end
                OP_ENTRY:
                begin
                    arch_regs[arch_wbase + {2'b00, arch_callinc} + {2'b00, it.ra}]
                        = lhs - it.imm;
                    arch_wbase   = arch_wbase + {2'b00, arch_callinc};
                    arch_callinc = '0;
                end
                OP_RETW:
                begin
                    if (arch_depth == 0)
                    begin
                        arch_running = 1'b0;
                        r.st   = ST_HALTED;
                        commit = 1'b0;
                        r.npc  = arch_pc;
                    end
                    else
                    begin
                        d = reg_rd(4'd2);
                        q = reg_rd(4'd3);
                        arch_depth--;
                        foreach (arch_regs[i]) arch_regs[i] = frame_snap[arch_depth][i];
                        arch_wbase = frame_wbase[arch_depth];
                        reg_wr(4'd10, d);
                        reg_wr(4'd11, q);
                        r.npc = frame_ret[arch_depth];
                    end
                end
                OP_BREAK: begin r.st = ST_TRAP; r.trap = it.imm; end
                OP_SLLI:  reg_wr(it.rd, lhs << it.imm[4:0]);
                OP_SRAI:  reg_wr(it.rd, $signed(lhs) >>> it.imm[4:0]);
                OP_SRLI:  reg_wr(it.rd, lhs >> it.imm[4:0]);
                OP_SSL, OP_SSR: arch_sar = lhs[4:0];
                OP_SLL:   reg_wr(it.rd, lhs << arch_sar);
                OP_SRL:   reg_wr(it.rd, lhs >> arch_sar);
                OP_SRA:   reg_wr(it.rd, $signed(lhs) >>> arch_sar);
                OP_MULL:  reg_wr(it.rd, lhs * rhs);
                OP_QUOU:  reg_wr(it.rd, (rhs == 0) ? 32'hffff_ffff : lhs / rhs);
                OP_REMU:  reg_wr(it.rd, (rhs == 0) ? lhs : lhs % rhs);
                OP_QUOS, OP_REMS:
                begin
                    // Work on magnitudes; the sign is applied afterwards.
                    mag_a = lhs[31] ? -lhs : lhs;
                    mag_b = rhs[31] ? -rhs : rhs;
                    if (op_t'(it.opc) == OP_QUOS)
                    begin
                        if (rhs == 0)
                            d = 32'hffff_ffff;
                        else if (lhs == 32'h8000_0000 && rhs == 32'hffff_ffff)
                            d = 32'h8000_0000;
                        else
                        begin
                            q = mag_a / mag_b;
                            d = (lhs[31] ^ rhs[31]) ? -q : q;
                        end
                    end
                    else
                    begin
                        if (rhs == 0)
                            d = lhs;
                        else if (lhs == 32'h8000_0000 && rhs == 32'hffff_ffff)
                            d = '0;
                        else
                        begin
                            q = mag_a % mag_b;
                            d = lhs[31] ? -q : q;
                        end
                    end
                    reg_wr(it.rd, d);
                end
                default:
                begin
                    r.st   = ST_INVALID;
                    commit = 1'b0;
                    r.npc  = arch_pc;
                end
            endcase
            if (commit)
                arch_pc = r.npc;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one transaction and hold it until the unit takes it. The expected
    // result is computed at the accepting edge. tvalid is left high so that a
    // back-to-back transaction never drops and raises it in the same step.
    task automatic send_item(input instr_t it);
        int gap;
        gap = tx_eager ? 0 : idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.is_load_data;
        s_axis_tdata  <= {4'd0, it.ldata, it.len, it.imm, it.rb, it.ra, it.rd, it.opc};
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        expected_results.push_back(execute_instr(it));
    endtask

    task automatic issue(input op_t op, input logic [3:0] rd, input logic [3:0] ra,
                         input logic [3:0] rb, input logic [31:0] imm);
        instr_t it;
        it = '{is_load_data: 1'b0, opc: op, rd: rd, ra: ra, rb: rb, imm: imm,
               len: 2'(2 + $urandom_range(0, 1)), ldata: $urandom};
        send_item(it);
    endtask

    task automatic return_load(input logic [31:0] data);
        instr_t it;
        it = '{is_load_data: 1'b1, opc: 6'($urandom), rd: 4'($urandom), ra: 4'($urandom),
               rb: 4'($urandom), imm: $urandom, len: 2'($urandom), ldata: data};
        send_item(it);
    endtask

    // Drop tvalid, wait for every result, then let the unit idle.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        if (idx == CFG_START_PC)
            arch_pc = value;
        else
            reg_wr(4'd1, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_imm();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000 + $urandom_range(0, 1) * 32'h7fff_ffff;
            1, 2:    return $urandom;
            default: return 32'($signed($urandom_range(0, 128)) - 64);
        endcase
    endfunction

    // Random instruction shaped by the shadow state: loads are mostly followed
    // by their data, calls mostly by an entry, and the call depth stays in
    // range so the unit keeps running.
    function automatic instr_t rand_instr();
        instr_t it;
        int     p;
        it = '{is_load_data: 1'b0, opc: '0, rd: 4'($urandom), ra: 4'($urandom),
               rb: 4'($urandom), imm: rand_imm(), len: 2'(2 + $urandom_range(0, 1)),
               ldata: $urandom};
        if ($urandom_range(0, 9) == 0)
            it.len = 2'($urandom_range(0, 3));
        if (load_pending)
        begin
            it.is_load_data = ($urandom_range(0, 9) != 0);
            it.opc = 6'($urandom_range(0, 63));
            return it;
        end
        if (after_call && $urandom_range(0, 9) < 7)
        begin
            after_call = 1'b0;
            it.opc = OP_ENTRY;
            it.ra  = 4'd1;
            it.imm = 32'($urandom_range(0, 8) * 16);
            return it;
        end
        after_call = 1'b0;
        p = $urandom_range(0, 99);
        if (p < 4)       it.is_load_data = 1'b1;
        else if (p < 30) it.opc = 6'($urandom_range(OP_ADD, OP_MOVI));
        else if (p < 40) it.opc = 6'($urandom_range(OP_L8UI, OP_L32I));
        else if (p < 42) it.opc = OP_L32R;
        else if (p < 50) it.opc = 6'($urandom_range(OP_S8I, OP_S32I));
        else if (p < 62) it.opc = 6'($urandom_range(OP_BEQ, OP_JX));
        else if (p < 74) it.opc = 6'($urandom_range(OP_SLLI, OP_SRA));
        else if (p < 84) it.opc = 6'($urandom_range(OP_MULL, OP_REMS));
        else if (p < 87) it.opc = OP_BREAK;
        else if (p < 89) it.opc = 6'($urandom_range(OP_INVALID, 63));
        else if (p < 94 && arch_depth < DEPTH - 1)
        begin
            it.opc = $urandom_range(0, 1) ? OP_CALL8 : OP_CALLX8;
            after_call = 1'b1;
        end
        else if (p < 96) it.opc = OP_ENTRY;
        else if (arch_depth > 0) it.opc = OP_RETW;
        else it.opc = OP_MOVI;
        // Point half of the OP_L32R loads at register 0.
        if (it.opc == OP_L32R && $urandom_range(0, 1))
            it.rd = 4'd0;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Receiver and result checker
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end
            else if (rx_eager)
                m_axis_tready <= 1'b1;
            else if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t exp_r;
        outcome_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{st: status_t'(m_axis_tuser), npc: m_axis_tdata[31:0],
                    addr: m_axis_tdata[63:32], wr: m_axis_tdata[64],
                    nbytes: m_axis_tdata[67:65], wdata: m_axis_tdata[99:68],
                    trap: m_axis_tdata[131:100]};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result transaction with none expected: status %0d pc %h",
                             $realtime, got.st, got.npc);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.st !== exp_r.st || got.npc !== exp_r.npc || got.addr !== exp_r.addr
                    || got.wr !== exp_r.wr || got.nbytes !== exp_r.nbytes
                    || got.wdata !== exp_r.wdata || got.trap !== exp_r.trap)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%t: mismatch\n  expected st %0d pc %h addr %h wr %b",
                                  " n %0d wdata %h trap %h\n  actual   st %0d pc %h",
                                  " addr %h wr %b n %0d wdata %h trap %h"}, $realtime,
                                 exp_r.st, exp_r.npc, exp_r.addr, exp_r.wr, exp_r.nbytes,
                                 exp_r.wdata, exp_r.trap, got.st, got.npc, got.addr,
                                 got.wr, got.nbytes, got.wdata, got.trap);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // ALU extremes, immediate and register shifts, a branch and break.
    task automatic test_alu_edges();
        issue(OP_MOVI, 4'd2, 4'd0, 4'd0, 32'h7fff_ffff);
        issue(OP_MOVI, 4'd3, 4'd0, 4'd0, 32'h8000_0000);
        issue(OP_ADD,  4'd4, 4'd2, 4'd3, 32'd0);
        issue(OP_SUB,  4'd5, 4'd3, 4'd2, 32'd0);
        issue(OP_XOR,  4'd6, 4'd4, 4'd3, 32'd0);
        issue(OP_NEG,  4'd7, 4'd3, 4'd0, 32'd0);
        issue(OP_ADDI, 4'd8, 4'd2, 4'd0, 32'd1);
        issue(OP_SRAI, 4'd9, 4'd3, 4'd0, 32'hffff_ffff);
        issue(OP_SSR,  4'd0, 4'd4, 4'd0, 32'd0);
        issue(OP_SRA,  4'd10, 4'd4, 4'd0, 32'd0);
        issue(OP_BLT,  4'd0, 4'd3, 4'd2, 32'hffff_fff0);
        issue(OP_BREAK, 4'd0, 4'd0, 4'd0, 32'hdead_beef);
    endtask

    // Loads with byte zero and halfword sign extension, the literal load, stores,
    // and the two protocol errors around a pending load.
    task automatic test_memory();
        return_load(32'h1234_5678);                     // nothing pending
        issue(OP_L16SI, 4'd11, 4'd3, 4'd0, 32'd2);
        issue(OP_ADD, 4'd0, 4'd1, 4'd2, 32'd0);         // instruction while pending
        return_load(32'h0000_8001);
        issue(OP_L8UI, 4'd12, 4'd2, 4'd0, 32'hffff_ffff);
        return_load(32'hffff_ffff);
        issue(OP_L32R, 4'd13, 4'd0, 4'd0, 32'hffff_fffc);
        return_load(32'hcafe_f00d);
        issue(OP_S8I,  4'd11, 4'd2, 4'd0, 32'd1);
        issue(OP_S16I, 4'd13, 4'd2, 4'd0, 32'd0);
        issue(OP_S32I, 4'd3,  4'd0, 4'd0, 32'h8000_0000);
    endtask

    // Divide by zero and signed overflow, plus opcodes outside the set.
    task automatic test_divide_invalid();
        issue(OP_MOVI, 4'd14, 4'd0, 4'd0, 32'hffff_ffff);
        issue(OP_MOVI, 4'd15, 4'd0, 4'd0, 32'd0);
        issue(OP_QUOS, 4'd4, 4'd3, 4'd14, 32'd0);
        issue(OP_REMS, 4'd5, 4'd3, 4'd14, 32'd0);
        issue(OP_QUOU, 4'd6, 4'd2, 4'd15, 32'd0);
        issue(OP_REMS, 4'd7, 4'd3, 4'd15, 32'd0);
        issue(OP_INVALID, 4'd0, 4'd0, 4'd0, 32'd0);
        issue(op_t'(6'd63), 4'd0, 4'd0, 4'd0, 32'd0);
    endtask

    // One nested call with window rotation and return value passing.
    task automatic test_call_return();
        issue(OP_CALL8, 4'd0, 4'd0, 4'd0, 32'h100);
        issue(OP_ENTRY, 4'd0, 4'd1, 4'd0, 32'd32);
        issue(OP_MOVI,  4'd2, 4'd0, 4'd0, 32'h5555_aaaa);
        issue(OP_CALLX8, 4'd0, 4'd2, 4'd0, 32'd0);
        issue(OP_RETW,  4'd0, 4'd0, 4'd0, 32'd0);
        issue(OP_RETW,  4'd0, 4'd0, 4'd0, 32'd0);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 80 == 0)
            begin
                tx_eager = ($urandom_range(0, 3) == 0);
                rx_eager = ($urandom_range(0, 3) == 0);
            end
            send_item(rand_instr());
        end
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    // Block the receiver while the sender keeps offering items.
    task automatic test_backpressure();
        rx_hold  = 400;
        tx_eager = 1'b1;
        test_random(30);
        settle();
    endtask

    // Fill the frame store; the next call stops the unit for good.
    task automatic test_depth_overflow();
        while (load_pending)
            return_load($urandom);
        while (arch_depth < DEPTH)
            issue(OP_CALL8, 4'd0, 4'd0, 4'd0, rand_imm());
        issue(OP_CALLX8, 4'd0, 4'd1, 4'd0, 32'd0);
        issue(OP_ADD, 4'd1, 4'd1, 4'd1, 32'd0);
        return_load(32'h0);
        issue(OP_RETW, 4'd0, 4'd0, 4'd0, 32'd0);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_START_PC;
        cfg_data      = '0;
        rx_hold       = 0;
        rx_eager      = 1'b0;
        tx_eager      = 1'b0;
        after_call    = 1'b0;
        mismatches    = 0;
        arch_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_cfg(CFG_START_PC, 32'hffff_fff0);
        write_cfg(CFG_STACK_TOP, 32'hffff_ffff);
        test_alu_edges();
        test_memory();
        test_divide_invalid();
        test_call_return();
        settle();

        // Random traffic across several register settings.
        write_cfg(CFG_START_PC, 32'h0);
        write_cfg(CFG_STACK_TOP, 32'h0);
        test_random(320);
        test_backpressure();
        write_cfg(CFG_START_PC, $urandom);
        write_cfg(CFG_STACK_TOP, $urandom);
        test_random(320);
        settle();
        write_cfg(CFG_STACK_TOP, 32'h8000_0000);
        write_cfg(CFG_START_PC, 32'h0000_1000);
        test_random(320);
        settle();
        write_cfg(CFG_START_PC, 32'hffff_ffff);
        test_random(250);
        test_depth_overflow();
        settle();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
hw/rtl/wreu_pkg.sv
hw/rtl/wreu_ram.sv
hw/rtl/wreu_div.sv
hw/rtl/windowed_risc_execute_unit.sv
verif/tb_windowed_risc_execute_unit.sv
